/* design/qrm_pkg.sv */
package qrm_pkg;

    typedef logic signed [31:0] q_t;
    typedef logic signed [63:0] prod_t;

    localparam q_t QMAX = 32'sh7fff_ffff;
    localparam q_t QMIN = 32'sh8000_0000;
    localparam q_t QONE = 32'sh0001_0000;

    // clamp a 33-bit exact sum to the 32-bit range
    function automatic q_t sat33(input logic signed [32:0] v);
        q_t r;
        if (v[32] != v[31])
        begin
            r = v[32] ? QMIN : QMAX;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // drop 16 fraction bits (floor) and clamp
    function automatic q_t sat_shift(input prod_t p);
        logic signed [47:0] s;
        q_t r;
        s = p[63:16];
        if ((&s[47:31]) || !(|s[47:31]))
        begin
            r = s[31:0];
        end
        else
        begin
            r = s[47] ? QMIN : QMAX;
        end
        return r;
    endfunction

    function automatic q_t qadd(input q_t a, input q_t b);
        return sat33({a[31], a} + {b[31], b});
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b);
        return sat33({a[31], a} - {b[31], b});
    endfunction

    function automatic q_t qdbl(input q_t a);
        return sat33({a, 1'b0});
    endfunction

endpackage

/* design/qrm_mul_lanes.sv */
module qrm_mul_lanes #(
    parameter int LANES = 16
) (
    input  logic          clk,
    input  logic          en,
    input  qrm_pkg::q_t   op_a [LANES],
    input  qrm_pkg::q_t   op_b [LANES],
    output qrm_pkg::q_t   q    [LANES]
);
    import qrm_pkg::*;

    prod_t prod_reg [LANES];
    q_t    q_reg    [LANES];

    // first stage: raw product, second stage: floor shift and clamp
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                prod_reg[i] <= prod_t'(op_a[i]) * prod_t'(op_b[i]);
                q_reg[i]    <= sat_shift(prod_reg[i]);
            end
        end
    end

    assign q = q_reg;

endmodule

/* design/quaternion_rotate_and_multiply.sv */
// throughput: one beat per cycle while the output is not stalled, 16 multipliers up front, 9 more for the vector rotate
// a stalled output freezes the whole pipeline, no beat is lost or repeated
// reset clears the stage valid bits only, payload registers are not reset
module quaternion_rotate_and_multiply (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          mode,
    input  qrm_pkg::q_t   a_w,
    input  qrm_pkg::q_t   a_x,
    input  qrm_pkg::q_t   a_y,
    input  qrm_pkg::q_t   a_z,
    input  qrm_pkg::q_t   b_w,
    input  qrm_pkg::q_t   b_x,
    input  qrm_pkg::q_t   b_y,
    input  qrm_pkg::q_t   b_z,
    output logic          out_valid,
    input  logic          out_stall,
    output qrm_pkg::q_t   r_w,
    output qrm_pkg::q_t   r_x,
    output qrm_pkg::q_t   r_y,
    output qrm_pkg::q_t   r_z
);
    import qrm_pkg::*;

    localparam int DEPTH = 8;

    logic             en;
    logic [DEPTH:1]   vld_reg;
    logic [DEPTH:1]   vld_next;
    logic [DEPTH:1]   mode_reg;

    q_t opa [16];
    q_t opb [16];
    q_t qa  [16];
    q_t qb  [9];
    q_t opc [9];
    q_t opd [9];

    q_t bv1_reg [3];
    q_t bv2_reg [3];
    q_t bv3_reg [3];
    q_t bv4_reg [3];
    q_t sum3_reg  [9];
    q_t rest3_reg [8];
    q_t mat4_reg  [9];
    q_t rest4_reg [4];
    q_t fin5_reg  [4];
    q_t fin6_reg  [4];
    q_t fin7_reg  [4];
    q_t row7_reg  [3];
    q_t q6_hold_reg [3];
    q_t r_reg [4];

    q_t sum3_next [9];
    q_t mat4_next [9];
    q_t fin5_next [4];
    q_t r_next    [4];

    assign en        = !(vld_reg[DEPTH] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[DEPTH];

    assign vld_next = {vld_reg[DEPTH-1:1], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // operand pairs: Hamilton lanes by default, rotate lanes 0..8 are
    // yy zz xy wz xz wy xx yz wx
    always_comb
    begin
        opa = '{a_w, a_x, a_y, a_z, a_w, a_x, a_y, a_z,
                a_w, a_x, a_y, a_z, a_w, a_x, a_y, a_z};
        opb = '{b_w, b_x, b_y, b_z, b_x, b_w, b_z, b_y,
                b_y, b_z, b_w, b_x, b_z, b_y, b_x, b_w};
        if (!mode)
        begin
            opa[0] = a_y;  opb[0] = a_y;
            opa[1] = a_z;  opb[1] = a_z;
            opa[2] = a_x;  opb[2] = a_y;
            opa[3] = a_w;  opb[3] = a_z;
            opa[4] = a_x;  opb[4] = a_z;
            opa[5] = a_w;  opb[5] = a_y;
            opa[6] = a_x;  opb[6] = a_x;
            opa[7] = a_y;  opb[7] = a_z;
            opa[8] = a_w;  opb[8] = a_x;
        end
    end

    qrm_mul_lanes #(
        .LANES (16)
    ) u_mul_a (
        .clk  (clk),
        .en   (en),
        .op_a (opa),
        .op_b (opb),
        .q    (qa)
    );

    // first level of adds
    always_comb
    begin
        sum3_next[0] = mode_reg[2] ? qsub(qa[0], qa[1])   : qadd(qa[0], qa[1]);
        sum3_next[1] = mode_reg[2] ? qadd(qa[4], qa[5])   : qsub(qa[2], qa[3]);
        sum3_next[2] = mode_reg[2] ? qsub(qa[8], qa[9])   : qadd(qa[4], qa[5]);
        sum3_next[3] = mode_reg[2] ? qadd(qa[12], qa[13]) : qadd(qa[2], qa[3]);
        sum3_next[4] = qadd(qa[6], qa[1]);
        sum3_next[5] = qsub(qa[7], qa[8]);
        sum3_next[6] = qsub(qa[4], qa[5]);
        sum3_next[7] = qadd(qa[7], qa[8]);
        sum3_next[8] = qadd(qa[6], qa[0]);
    end

    // rotate: matrix terms; Hamilton: second accumulate
    always_comb
    begin
        mat4_next[0] = qsub(QONE, qdbl(sum3_reg[0]));
        mat4_next[1] = qdbl(sum3_reg[1]);
        mat4_next[2] = qdbl(sum3_reg[2]);
        mat4_next[3] = qdbl(sum3_reg[3]);
        mat4_next[4] = qsub(QONE, qdbl(sum3_reg[4]));
        mat4_next[5] = qdbl(sum3_reg[5]);
        mat4_next[6] = qdbl(sum3_reg[6]);
        mat4_next[7] = qdbl(sum3_reg[7]);
        mat4_next[8] = qsub(QONE, qdbl(sum3_reg[8]));
        if (mode_reg[3])
        begin
            mat4_next[0] = qsub(sum3_reg[0], rest3_reg[0]);
            mat4_next[1] = qadd(sum3_reg[1], rest3_reg[2]);
            mat4_next[2] = qadd(sum3_reg[2], rest3_reg[4]);
            mat4_next[3] = qsub(sum3_reg[3], rest3_reg[6]);
        end
    end

    always_comb
    begin
        fin5_next[0] = qsub(mat4_reg[0], rest4_reg[0]);
        fin5_next[1] = qsub(mat4_reg[1], rest4_reg[1]);
        fin5_next[2] = qadd(mat4_reg[2], rest4_reg[2]);
        fin5_next[3] = qadd(mat4_reg[3], rest4_reg[3]);
    end

    // row i lane j multiplies vector component j by m[i][j]
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                opc[3*i+j] = bv4_reg[j];
                opd[3*i+j] = mat4_reg[3*i+j];
            end
        end
    end

    qrm_mul_lanes #(
        .LANES (9)
    ) u_mul_b (
        .clk  (clk),
        .en   (en),
        .op_a (opc),
        .op_b (opd),
        .q    (qb)
    );

    always_comb
    begin
        if (mode_reg[7])
        begin
            r_next = fin7_reg;
        end
        else
        begin
            r_next[0] = '0;
            for (int i = 0; i < 3; i++)
            begin
                r_next[i+1] = qadd(row7_reg[i], q6_hold_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_reg  <= {mode_reg[DEPTH-1:1], mode};
            bv1_reg   <= '{b_x, b_y, b_z};
            bv2_reg   <= bv1_reg;
            bv3_reg   <= bv2_reg;
            bv4_reg   <= bv3_reg;
            sum3_reg  <= sum3_next;
            rest3_reg <= '{qa[2], qa[3], qa[6], qa[7], qa[10], qa[11], qa[14], qa[15]};
            mat4_reg  <= mat4_next;
            rest4_reg <= '{rest3_reg[1], rest3_reg[3], rest3_reg[5], rest3_reg[7]};
            fin5_reg  <= fin5_next;
            fin6_reg  <= fin5_reg;
            fin7_reg  <= fin6_reg;
            for (int i = 0; i < 3; i++)
            begin
                row7_reg[i]    <= qadd(qb[3*i], qb[3*i+1]);
                q6_hold_reg[i] <= qb[3*i+2];
            end
            r_reg <= r_next;
        end
    end

    assign r_w = r_reg[0];
    assign r_x = r_reg[1];
    assign r_y = r_reg[2];
    assign r_z = r_reg[3];

    a_rot_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !mode_reg[DEPTH]) |-> (r_w == '0))
        else $error("rotate beat with nonzero r_w");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(vld_reg) && $stable(mode_reg)))
        else $error("pipeline moved under output stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[1])
        else $error("accepted beat did not enter first stage");

    a_beat_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[DEPTH-1] && !in_stall) |=> out_valid)
        else $error("beat lost before output stage");

endmodule
